FILE: sv/zero_crossing_bit_slicer_defines.svh
// ----------------------------------------------------------------------------
// zero crossing bit slicer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef ZERO_CROSSING_BIT_SLICER_DEFINES_SVH
`define ZERO_CROSSING_BIT_SLICER_DEFINES_SVH

// next-cycle implication, off while reset is low
`define ZCBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// state of the ports in the cycle after a reset
`define ZCBS_ASSERT_AFTER_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/zcbs_pkg.sv
// ----------------------------------------------------------------------------
// zcbs_pkg
// types and constants shared by the zero crossing bit slicer
// ----------------------------------------------------------------------------
package zcbs_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SAMPLE_W   = 16;
  localparam int LEN_W      = 16;
  localparam int FRAC_W     = 16;
  localparam int DIV_W      = 16;
  localparam int DIV_LOW_W  = 17;
  localparam int DIV_CNT_W  = 5;

  localparam logic [7:0]           BYTE_OFFSET = 8'h80;
  localparam logic [CFG_DATA_W-1:0] SPB_RESET  = 16'd2560;
  localparam logic [LEN_W-1:0]     LEN_MAX     = '1;
  localparam logic [FRAC_W-1:0]    FRAC_MAX    = '1;
  localparam logic [DIV_CNT_W-1:0] ITERS_SHORT = 5'd16;
  localparam logic [DIV_CNT_W-1:0] ITERS_LONG  = 5'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIXTEEN_BIT = 3'd0,
    CFG_AVERAGE     = 3'd1,
    CFG_FINE        = 3'd2,
    CFG_INVERT      = 3'd3,
    CFG_SPB         = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SIGN_NONE = 2'd0,
    SIGN_POS  = 2'd1,
    SIGN_NEG  = 2'd2
  } sign_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_AVG_DIV,
    ST_SLICE,
    ST_FRAC_DIV,
    ST_LEN_PREP,
    ST_LEN_LOAD,
    ST_LEN_DIV,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] iters;
  } div_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_LOW_W-1:0] quo;
  } div_rsp_t;

endpackage

FILE: sv/zcbs_serial_div.sv
// ----------------------------------------------------------------------------
// zcbs_serial_div
// restoring divider, one quotient bit per cycle, shared by all divides
// ----------------------------------------------------------------------------
module zcbs_serial_div import zcbs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  div_cmd_t             cmd,
  input  logic [DIV_W-1:0]     rem_init,
  input  logic [DIV_LOW_W-1:0] low_init,
  input  logic [DIV_W-1:0]     divisor,
  output div_rsp_t             rsp
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0]     rem_r;
  logic [DIV_W-1:0]     rem_nxt;
  logic [DIV_LOW_W-1:0] low_r;
  logic [DIV_LOW_W-1:0] quo_r;
  logic [DIV_W-1:0]     dvs_r;
  logic [DIV_W+1:0]     trial;
  logic                 ge;

  always_comb begin
    trial   = {1'b0, rem_r, low_r[DIV_LOW_W-1]} - {2'b00, dvs_r};
    ge      = ~trial[DIV_W+1];
    rem_nxt = ge ? trial[DIV_W-1:0] : {rem_r[DIV_W-2:0], low_r[DIV_LOW_W-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= rem_init;
      low_r <= low_init;
      dvs_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= {low_r[DIV_LOW_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_LOW_W-2:0], ge};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

FILE: sv/zcbs_window.sv
// ----------------------------------------------------------------------------
// zcbs_window
// moving average sample store with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
module zcbs_window import zcbs_pkg::*; #(
  parameter int  DEPTH = 8,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [IDX_W-1:0]           idx,
  input  logic                       wr_en,
  input  logic signed [SAMPLE_W-1:0] wr_data,
  output logic signed [SAMPLE_W-1:0] rd_data
);

  logic signed [SAMPLE_W-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0]           valid_r;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic                       rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[idx] <= wr_data;
    end
    rd_r <= mem_r[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[idx] <= 1'b1;
      end
      rd_valid_r <= valid_r[idx];
    end
  end

  assign rd_data = rd_valid_r ? rd_r : '0;

endmodule

FILE: sv/zero_crossing_bit_slicer.sv
// ----------------------------------------------------------------------------
// zero crossing bit slicer
// each sample is sliced, after a serial divide by 2L when averaging
// a sign change adds the length divide (skipped when it saturates), after
// a fraction divide with fine length; the result goes to output registers
// one sample at a time, paced by the shared bit-serial divider
// sync reset clears control state and window valid bits in a reset cycle
// ----------------------------------------------------------------------------
module zero_crossing_bit_slicer import zcbs_pkg::*; #(
  parameter int AVERAGE_LENGTH = 8,
  parameter int RUN_COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_raw_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_bit_value,
  output logic [LEN_W-1:0]      out_length_in_bits
);

  localparam int IDX_W = $clog2(AVERAGE_LENGTH);
  localparam int SUM_W = SAMPLE_W + 1 + IDX_W;
  localparam int AVG_W = SUM_W + 1;
  localparam int N_W   = RUN_COUNT_BITS + 17;
  localparam int NS_W  = N_W + 1;
  localparam int HI_W  = N_W - 24;
  localparam logic [IDX_W-1:0]          IDX_LAST    = IDX_W'(AVERAGE_LENGTH - 1);
  localparam logic [DIV_W-1:0]          AVG_DIVISOR = DIV_W'(2 * AVERAGE_LENGTH);
  localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX     = '1;

  state_t state_r, state_nxt;

  logic                  sixteen_r;
  logic                  avg_en_r;
  logic                  fine_r;
  logic                  invert_r;
  logic [CFG_DATA_W-1:0] spb_r;

  logic signed [SUM_W-1:0]    sum_r;
  logic [IDX_W-1:0]           idx_r;
  logic signed [SAMPLE_W-1:0] prev_r;
  sign_t                      sign_r;
  logic [RUN_COUNT_BITS-1:0]  run_r;
  logic [FRAC_W-1:0]          pfrac_r;
  logic                       out_valid_r;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [N_W-1:0]             n_r;
  logic [LEN_W-1:0]           len_r;
  logic                       bit_r;
  logic                       avg_neg_r;
  logic                       den_zero_r;
  logic                       out_bit_r;
  logic [LEN_W-1:0]           out_len_r;

  logic signed [SAMPLE_W-1:0] sample_cvt;
  logic signed [SAMPLE_W-1:0] win_old;
  logic signed [SUM_W-1:0]    sum_nxt;
  logic [AVG_W-1:0]           avg_twice;
  logic [AVG_W-1:0]           avg_mag;
  logic [SAMPLE_W-1:0]        avg_q;
  logic [SAMPLE_W-1:0]        avg_val;
  sign_t                      cur_sign;
  logic [RUN_COUNT_BITS-1:0]  run_inc;
  logic                       crossing;
  logic [SAMPLE_W-1:0]        num;
  logic [SAMPLE_W:0]          diff;
  logic [DIV_W-1:0]           den;
  logic [FRAC_W-1:0]          frac_val;
  logic [NS_W-1:0]            n_full;
  logic [CFG_DATA_W-1:0]      spb_eff;
  logic [N_W-1:0]             len_sum;
  logic [HI_W-1:0]            len_hi;
  logic                       len_ovf;

  logic                 win_wr_en;
  logic                 out_load;
  div_cmd_t             div_cmd;
  div_rsp_t             div_rsp;
  logic [DIV_W-1:0]     div_rem_init;
  logic [DIV_LOW_W-1:0] div_low_init;
  logic [DIV_W-1:0]     div_divisor;

  zcbs_window #(
    .DEPTH (AVERAGE_LENGTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .idx     (idx_r),
    .wr_en   (win_wr_en),
    .wr_data (sample_r),
    .rd_data (win_old)
  );

  zcbs_serial_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .rem_init (div_rem_init),
    .low_init (div_low_init),
    .divisor  (div_divisor),
    .rsp      (div_rsp)
  );

  // sample conversion and datapath terms
  always_comb begin
    sample_cvt = sixteen_r ? $signed(in_raw_sample)
                           : $signed({{8{~in_raw_sample[7]}}, in_raw_sample[7:0] ^ BYTE_OFFSET});

    sum_nxt   = sum_r - SUM_W'(win_old) + SUM_W'(sample_r);
    avg_twice = {sum_nxt, 1'b1};
    avg_mag   = sum_nxt[SUM_W-1] ? (~avg_twice + AVG_W'(1)) : avg_twice;
    avg_q     = div_rsp.quo[SAMPLE_W-1:0];
    avg_val   = avg_neg_r ? (~avg_q + SAMPLE_W'(1)) : avg_q;

    cur_sign = sample_r[SAMPLE_W-1] ? SIGN_NEG : SIGN_POS;
    run_inc  = (run_r == RUN_MAX) ? run_r : run_r + 1'b1;
    crossing = (sign_r != SIGN_NONE) && (cur_sign != sign_r);
    num      = sample_r[SAMPLE_W-1] ? (~SAMPLE_W'(sample_r) + SAMPLE_W'(1))
                                    : SAMPLE_W'(sample_r);
    diff     = (SAMPLE_W+1)'(sample_r) - (SAMPLE_W+1)'(prev_r);
    den      = diff[SAMPLE_W] ? DIV_W'(~diff + (SAMPLE_W+1)'(1)) : diff[DIV_W-1:0];
    frac_val = den_zero_r ? '0 :
               (div_rsp.quo[DIV_LOW_W-1] ? FRAC_MAX : div_rsp.quo[FRAC_W-1:0]);

    n_full = NS_W'({run_r, 16'h0000}) + (fine_r ? (NS_W'(pfrac_r) - NS_W'(frac_r)) : '0);

    spb_eff = (spb_r == '0) ? CFG_DATA_W'(1) : spb_r;
    len_sum = n_r + N_W'({spb_eff, 7'b0});
    len_hi  = len_sum[N_W-1:24];
    len_ovf = 32'(len_hi) >= 32'(spb_eff);
  end

  // divider operand select
  always_comb begin
    case (state_r)
      ST_AVG: begin
        div_rem_init = DIV_W'(avg_mag[AVG_W-1:16]);
        div_low_init = {avg_mag[15:0], 1'b0};
        div_divisor  = AVG_DIVISOR;
      end
      ST_SLICE: begin
        div_rem_init = {1'b0, num[SAMPLE_W-1:1]};
        div_low_init = {num[0], 16'h0000};
        div_divisor  = den;
      end
      default: begin
        div_rem_init = DIV_W'(len_hi);
        div_low_init = {len_sum[23:8], 1'b0};
        div_divisor  = spb_eff;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    win_wr_en     = 1'b0;
    out_load      = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.iters = ITERS_SHORT;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = avg_en_r ? ST_AVG : ST_SLICE;
        end
      end
      ST_AVG: begin
        win_wr_en     = 1'b1;
        div_cmd.start = 1'b1;
        state_nxt     = ST_AVG_DIV;
      end
      ST_AVG_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_SLICE;
        end
      end
      ST_SLICE: begin
        if (crossing && fine_r) begin
          div_cmd.start = 1'b1;
          div_cmd.iters = ITERS_LONG;
          state_nxt     = ST_FRAC_DIV;
        end else if (crossing) begin
          state_nxt = ST_LEN_PREP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FRAC_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_LEN_PREP;
        end
      end
      ST_LEN_PREP: begin
        state_nxt = ST_LEN_LOAD;
      end
      ST_LEN_LOAD: begin
        if (len_ovf) begin
          state_nxt = ST_EMIT;
        end else begin
          div_cmd.start = 1'b1;
          state_nxt     = ST_LEN_DIV;
        end
      end
      ST_LEN_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_load = !out_valid_r || out_ready;
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sixteen_r   <= 1'b0;
      avg_en_r    <= 1'b0;
      fine_r      <= 1'b0;
      invert_r    <= 1'b0;
      spb_r       <= SPB_RESET;
      sum_r       <= '0;
      idx_r       <= '0;
      prev_r      <= '0;
      sign_r      <= SIGN_NONE;
      run_r       <= '0;
      pfrac_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_SIXTEEN_BIT: sixteen_r <= cfg_wr_data[0];
          CFG_AVERAGE:     avg_en_r  <= cfg_wr_data[0];
          CFG_FINE:        fine_r    <= cfg_wr_data[0];
          CFG_INVERT:      invert_r  <= cfg_wr_data[0];
          CFG_SPB:         spb_r     <= cfg_wr_data;
          default: begin
          end
        endcase
      end
      if (state_r == ST_AVG) begin
        sum_r <= sum_nxt;
      end
      if (state_r == ST_SLICE) begin
        idx_r  <= (idx_r == IDX_LAST) ? '0 : idx_r + 1'b1;
        prev_r <= sample_r;
        sign_r <= cur_sign;
        run_r  <= (sign_r == SIGN_NONE) ? '0 : run_inc;
      end
      if (state_r == ST_LEN_PREP) begin
        run_r <= '0;
        if (fine_r) begin
          pfrac_r <= frac_r;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_r <= sample_cvt;
    end
    if (state_r == ST_AVG) begin
      avg_neg_r <= sum_nxt[SUM_W-1];
    end
    if ((state_r == ST_AVG_DIV) && div_rsp.done) begin
      sample_r <= $signed(avg_val);
    end
    if (state_r == ST_SLICE) begin
      bit_r      <= (sign_r == SIGN_POS) ^ invert_r;
      den_zero_r <= (den == '0);
    end
    if ((state_r == ST_FRAC_DIV) && div_rsp.done) begin
      frac_r <= frac_val;
    end
    if (state_r == ST_LEN_PREP) begin
      n_r <= n_full[NS_W-1] ? '0 : n_full[N_W-1:0];
    end
    if ((state_r == ST_LEN_LOAD) && len_ovf) begin
      len_r <= LEN_MAX;
    end
    if ((state_r == ST_LEN_DIV) && div_rsp.done) begin
      len_r <= div_rsp.quo[LEN_W-1:0];
    end
    if (out_load) begin
      out_bit_r <= bit_r;
      out_len_r <= len_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bit_value      = out_bit_r;
  assign out_length_in_bits = out_len_r;

endmodule

FILE: sv/zcbs_checker.sv
// ----------------------------------------------------------------------------
// zcbs_checker
// port level checks for the zero crossing bit slicer, bound to the top level
// ----------------------------------------------------------------------------
`include "zero_crossing_bit_slicer_defines.svh"

module zcbs_checker import zcbs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_bit_value,
  input logic [LEN_W-1:0] out_length_in_bits
);

  `ZCBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bit_value) && $stable(out_length_in_bits), "result request changed while stalled")
  `ZCBS_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input ready right after a request was taken")
  `ZCBS_ASSERT_AFTER_RESET(a_reset_idle, !out_valid && in_ready, "ports not idle after reset")

endmodule

bind zero_crossing_bit_slicer zcbs_checker u_zcbs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_bit_value      (out_bit_value),
  .out_length_in_bits (out_length_in_bits)
);
